FILE: design/sfr_pkg.sv
package sfr_pkg;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [1:0] STATUS_GOOD    = 2'd0;
  localparam logic [1:0] STATUS_BAD_END = 2'd1;
  localparam logic [1:0] STATUS_BAD_CRC = 2'd2;

  localparam logic [1:0] CFG_NODE_ID    = 2'd0;
  localparam logic [1:0] CFG_START_BYTE = 2'd1;
  localparam logic [1:0] CFG_END_BYTE   = 2'd2;

  localparam int CFG_INDEX_W = 2;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [7:0]  sender_id;
    logic [7:0]  frame_type;
    logic [15:0] payload_length;
    logic [1:0]  status;
  } sfr_item_t;

  localparam int ITEM_W = $bits(sfr_item_t);

endpackage

FILE: design/serial_frame_receiver_crc16_top.sv
// Framed serial receiver with CRC-16 (poly 0x1021, init 0) check. One byte is
// taken per cycle while rx_stall is low; header fields or the CRC are updated
// in the same cycle, so the sustained rate is one byte per clock. Payload
// bytes of frames addressed to node_id come out as kind 0 beats, and a kind 1
// verdict beat follows the second CRC byte; frames for other nodes give none.
// Result beats wait in a queue of QUEUE_DEPTH entries ahead of the output
// register, and rx_stall rises only while that queue is full. Write the
// registers (0 node_id, 1 start_byte, 2 end_byte) only while the block is idle.
module serial_frame_receiver_crc16_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data,
  input  logic                            rx_valid,
  output logic                            rx_stall,
  input  logic [7:0]                      rx_byte,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic                            kind,
  output logic [7:0]                      data,
  output logic [7:0]                      sender_id,
  output logic [7:0]                      frame_type,
  output logic [15:0]                     payload_length,
  output logic [1:0]                      status
);
  import sfr_pkg::*;

  logic      push, queue_full, pop, head_valid;
  sfr_item_t push_item, head_item, res_item;

  sfr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .queue_full   (queue_full),
    .push         (push),
    .push_item    (push_item)
  );

  sfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (head_valid),
    .head_item (head_item)
  );

  sfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item)
  );

  assign kind           = res_item.kind;
  assign data           = res_item.data;
  assign sender_id      = res_item.sender_id;
  assign frame_type     = res_item.frame_type;
  assign payload_length = res_item.payload_length;
  assign status         = res_item.status;

endmodule

FILE: design/sfr_front.sv
module sfr_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_en,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [7:0]                         cfg_data,
  input  logic                               rx_valid,
  output logic                               rx_stall,
  input  logic [7:0]                         rx_byte,
  input  logic                               queue_full,
  output logic                               push,
  output sfr_pkg::sfr_item_t                 push_item
);
  import sfr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_HEAD = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  header_count, header_count_next;
  logic [7:0]  node_id, start_byte, end_byte;
  logic [7:0]  sender_reg, sender_reg_next;
  logic [7:0]  receiver_reg, receiver_reg_next;
  logic [7:0]  type_reg, type_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [16:0] bytes_left, bytes_left_next;
  logic [15:0] crc_acc, crc_acc_next;
  logic        end_ok, end_ok_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic        accept, mine;
  logic [15:0] crc_byte;
  logic [15:0] crc_got;

  function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = {c[7:0], c[15:8]};
    x = x ^ {8'h00, b};
    x = x ^ {12'h000, x[7:4]};
    x = x ^ {x[3:0], 12'h000};
    x = x ^ {3'b000, x[7:0], 5'b00000};
    return x;
  endfunction

  assign rx_stall = queue_full;
  assign accept   = rx_valid && !queue_full;
  assign mine     = (receiver_reg == node_id);
  assign crc_byte = crc_update(crc_acc, rx_byte);
  assign crc_got  = {rx_byte, crc_low_byte};

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    sender_reg_next   = sender_reg;
    receiver_reg_next = receiver_reg;
    type_reg_next     = type_reg;
    length_reg_next   = length_reg;
    bytes_left_next   = bytes_left;
    crc_acc_next      = crc_acc;
    end_ok_next       = end_ok;
    crc_low_byte_next = crc_low_byte;
    push              = 1'b0;
    push_item.kind           = KIND_PAYLOAD;
    push_item.data           = rx_byte;
    push_item.sender_id      = sender_reg;
    push_item.frame_type     = type_reg;
    push_item.payload_length = length_reg;
    push_item.status         = STATUS_GOOD;

    if (phase == PH_HEAD) begin
      crc_acc_next      = crc_byte;
      header_count_next = header_count + 3'd1;
      case (header_count)
        3'd0: sender_reg_next   = rx_byte;
        3'd1: receiver_reg_next = rx_byte;
        3'd2: type_reg_next     = rx_byte;
        3'd3: length_reg_next   = {8'h00, rx_byte};
        default: begin
          length_reg_next = {rx_byte, length_reg[7:0]};
          bytes_left_next = {1'b0, rx_byte, length_reg[7:0]} + 17'd3;
          phase_next      = PH_BODY;
        end
      endcase
    end else if (phase == PH_BODY && bytes_left != 17'd0) begin
      bytes_left_next = bytes_left - 17'd1;
      if (bytes_left > 17'd3) begin
        crc_acc_next = crc_byte;
        push         = mine;
      end else if (bytes_left == 17'd3) begin
        crc_acc_next = crc_byte;
        end_ok_next  = (rx_byte == end_byte);
      end else if (bytes_left == 17'd2) begin
        crc_low_byte_next = rx_byte;
      end else begin
        phase_next     = PH_HUNT;
        push           = mine;
        push_item.kind = KIND_VERDICT;
        push_item.data = 8'h00;
        // end byte is judged before the CRC
        if (!end_ok) begin
          push_item.status = STATUS_BAD_END;
        end else if (crc_got != crc_acc) begin
          push_item.status = STATUS_BAD_CRC;
        end else begin
          push_item.status = STATUS_GOOD;
        end
      end
    end else begin
      phase_next      = PH_HUNT;
      bytes_left_next = 17'd0;
      if (rx_byte == start_byte) begin
        crc_acc_next      = crc_update(16'h0000, rx_byte);
        header_count_next = 3'd0;
        phase_next        = PH_HEAD;
      end
    end

    if (!accept) begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      header_count <= 3'd0;
      node_id      <= 8'h00;
      start_byte   <= 8'h00;
      end_byte     <= 8'h00;
      sender_reg   <= 8'h00;
      receiver_reg <= 8'h00;
      type_reg     <= 8'h00;
      length_reg   <= 16'h0000;
      bytes_left   <= 17'd0;
      crc_acc      <= 16'h0000;
      end_ok       <= 1'b0;
      crc_low_byte <= 8'h00;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_NODE_ID:    node_id    <= cfg_data;
          CFG_START_BYTE: start_byte <= cfg_data;
          CFG_END_BYTE:   end_byte   <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        phase        <= phase_next;
        header_count <= header_count_next;
        sender_reg   <= sender_reg_next;
        receiver_reg <= receiver_reg_next;
        type_reg     <= type_reg_next;
        length_reg   <= length_reg_next;
        bytes_left   <= bytes_left_next;
        crc_acc      <= crc_acc_next;
        end_ok       <= end_ok_next;
        crc_low_byte <= crc_low_byte_next;
      end
    end
  end

endmodule

FILE: design/sfr_queue.sv
module sfr_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sfr_pkg::sfr_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output sfr_pkg::sfr_item_t head_item
);
  import sfr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sfr_item_t       slots [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: design/sfr_back.sv
module sfr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  sfr_pkg::sfr_item_t head_item,
  output logic               pop,
  output logic               res_valid,
  input  logic               res_stall,
  output sfr_pkg::sfr_item_t res_item
);
  import sfr_pkg::*;

  // refill the output register when it is empty or its beat is taken
  assign pop = head_valid && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      res_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_item <= head_item;
    end
  end

endmodule

FILE: sim/tb_serial_frame_receiver_crc16_top.sv
`timescale 1ns / 1ps

module tb_serial_frame_receiver_crc16_top;
  import sfr_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 16;
  localparam int TIMEOUT_NS   = 20_000_000;
  localparam int PHASE_BYTES  = 290;
  localparam int NUM_PHASES   = 6;

  typedef enum logic [1:0] {P_HUNT, P_HEAD, P_BODY, P_SPARE} parse_phase_t;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [7:0]             cfg_data     = '0;
  logic                   rx_valid     = 1'b0;
  logic                   rx_stall;
  logic [7:0]             rx_byte      = '0;
  logic                   res_valid;
  logic                   res_stall    = 1'b0;
  logic                   kind;
  logic [7:0]             data;
  logic [7:0]             sender_id;
  logic [7:0]             frame_type;
  logic [15:0]            payload_length;
  logic [1:0]             status;

  serial_frame_receiver_crc16_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .rx_valid       (rx_valid),
    .rx_stall       (rx_stall),
    .rx_byte        (rx_byte),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .kind           (kind),
    .data           (data),
    .sender_id      (sender_id),
    .frame_type     (frame_type),
    .payload_length (payload_length),
    .status         (status)
  );

  always #HALF_PERIOD clk = ~clk;

  // Register values as the block holds them
  logic [7:0] node_cfg  = 8'h00;
  logic [7:0] start_cfg = 8'h00;
  logic [7:0] end_cfg   = 8'h00;

  // Frame parser state
  parse_phase_t ps_phase    = P_HUNT;
  logic [2:0]   ps_hdr_cnt  = '0;
  logic [7:0]   ps_sender   = '0;
  logic [7:0]   ps_receiver = '0;
  logic [7:0]   ps_type     = '0;
  logic [15:0]  ps_length   = '0;
  logic [16:0]  ps_left     = '0;
  logic [15:0]  ps_crc      = '0;
  logic         ps_end_ok   = 1'b0;
  logic [7:0]   ps_crc_lo   = '0;

  logic [7:0] line_bytes[$];
  sfr_item_t  expected_beats[$];

  int fail_count    = 0;
  int bytes_sent    = 0;
  int frames_built  = 0;
  int beats_seen    = 0;
  int verdicts_seen = 0;
  int rx_gap        = 0;
  int rx_burst      = 0;
  int stall_left    = 0;
  int stall_burst   = 0;

  function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] x;
    x = {c[7:0], c[15:8]};
    x[7:0] = x[7:0] ^ b;
    x = x ^ {12'h000, x[7:4]};
    x = x ^ (x << 12);
    x = x ^ {3'b000, x[7:0], 5'b00000};
    return x;
  endfunction

  function automatic sfr_item_t make_beat(logic k, logic [7:0] d, logic [1:0] st);
    sfr_item_t r;
    r.kind           = k;
    r.data           = d;
    r.sender_id      = ps_sender;
    r.frame_type     = ps_type;
    r.payload_length = ps_length;
    r.status         = st;
    return r;
  endfunction

  // Advance the parser by one byte; return 1 when the byte yields a result beat
  function automatic bit parse_byte(input logic [7:0] b, output sfr_item_t beat);
    bit mine;
    mine = (ps_receiver == node_cfg);
    beat = '0;
    if (ps_phase == P_HEAD) begin
      ps_crc = crc16_step(ps_crc, b);
      case (ps_hdr_cnt)
        3'd0: ps_sender   = b;
        3'd1: ps_receiver = b;
        3'd2: ps_type     = b;
        3'd3: ps_length   = {8'h00, b};
        default: begin
          ps_length = {b, ps_length[7:0]};
          ps_left   = {1'b0, ps_length} + 17'd3;
          ps_phase  = P_BODY;
        end
      endcase
      ps_hdr_cnt = ps_hdr_cnt + 3'd1;
      return 1'b0;
    end
    if (ps_phase == P_BODY && ps_left != 0) begin
      if (ps_left > 17'd3) begin
        ps_crc  = crc16_step(ps_crc, b);
        ps_left = ps_left - 17'd1;
        if (mine) begin
          beat = make_beat(KIND_PAYLOAD, b, STATUS_GOOD);
          return 1'b1;
        end
        return 1'b0;
      end
      if (ps_left == 17'd3) begin
        ps_crc    = crc16_step(ps_crc, b);
        ps_end_ok = (b == end_cfg);
        ps_left   = ps_left - 17'd1;
        return 1'b0;
      end
      if (ps_left == 17'd2) begin
        ps_crc_lo = b;
        ps_left   = ps_left - 17'd1;
        return 1'b0;
      end
      ps_left  = '0;
      ps_phase = P_HUNT;
      if (mine) begin
        // a bad end byte outranks a bad CRC
        beat = make_beat(KIND_VERDICT, 8'h00,
                         !ps_end_ok ? STATUS_BAD_END :
                         ({b, ps_crc_lo} != ps_crc) ? STATUS_BAD_CRC : STATUS_GOOD);
        return 1'b1;
      end
      return 1'b0;
    end
    ps_phase = P_HUNT;
    ps_left  = '0;
    if (b == start_cfg) begin
      ps_crc     = crc16_step(16'h0000, b);
      ps_hdr_cnt = '0;
      ps_phase   = P_HEAD;
    end
    return 1'b0;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a stretch with none
  function automatic int idle_len(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst = $urandom_range(30, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == start_cfg);
    return b;
  endfunction

  task automatic build_frame(input logic [7:0] snd, input logic [7:0] rcv,
                             input logic [7:0] ftype, input logic [7:0] payload[$],
                             input bit bad_end, input bit bad_crc,
                             output logic [7:0] fb[$]);
    logic [15:0] len;
    logic [15:0] crc;
    len = 16'(payload.size());
    fb  = {start_cfg, snd, rcv, ftype, len[7:0], len[15:8]};
    foreach (payload[i]) fb.push_back(payload[i]);
    fb.push_back(bad_end ? (end_cfg ^ 8'(1 << $urandom_range(0, 7))) : end_cfg);
    crc = 16'h0000;
    foreach (fb[i]) crc = crc16_step(crc, fb[i]);
    if (bad_crc) crc = crc ^ 16'(1 << $urandom_range(0, 15));
    fb.push_back(crc[7:0]);
    fb.push_back(crc[15:8]);
    frames_built++;
  endtask

  task automatic send(input logic [7:0] fb[$]);
    foreach (fb[i]) line_bytes.push_back(fb[i]);
  endtask

  // Hold until every byte is taken and every beat has come, then let the pipe settle
  task automatic wait_drained();
    do @(negedge clk);
    while (line_bytes.size() != 0 || rx_valid || expected_beats.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    case (idx)
      CFG_NODE_ID:    node_cfg  = val;
      CFG_START_BYTE: start_cfg = val;
      CFG_END_BYTE:   end_cfg   = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic random_traffic(input int n_bytes);
    logic [7:0] pl[$];
    logic [7:0] fb[$];
    logic [7:0] rcv;
    int pushed;
    int r;
    int len;
    int cut;
    pushed = 0;
    while (pushed < n_bytes) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        repeat ($urandom_range(1, 4)) begin
          line_bytes.push_back(noise_byte());
          pushed++;
        end
      end else begin
        r   = $urandom_range(0, 99);
        len = (r < 80) ? $urandom_range(0, 6) :
              (r < 97) ? $urandom_range(7, 40) : $urandom_range(250, 300);
        pl = {};
        repeat (len) pl.push_back(8'($urandom));
        if ($urandom_range(0, 3) != 0) begin
          rcv = node_cfg;
        end else begin
          do rcv = 8'($urandom); while (rcv == node_cfg);
        end
        build_frame(8'($urandom), rcv, 8'($urandom), pl,
                    $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0, fb);
        // keep the header, overwrite the tail with line noise
        if ($urandom_range(0, 15) == 0) begin
          cut = $urandom_range(6, fb.size() - 1);
          for (int i = cut; i < fb.size(); i++) fb[i] = noise_byte();
        end
        pushed += fb.size();
        send(fb);
      end
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
  endtask

  // Driver: hold a stalled beat, otherwise take the next byte after its gap
  always @(posedge clk) begin
    sfr_item_t beat;
    if (rst) begin
      rx_valid <= 1'b0;
    end else begin
      if (rx_valid && !rx_stall) begin
        bytes_sent++;
        if (parse_byte(rx_byte, beat)) expected_beats.push_back(beat);
      end
      if (!rx_valid || !rx_stall) begin
        if (rx_gap > 0) begin
          rx_gap--;
          rx_valid <= 1'b0;
        end else if (line_bytes.size() > 0) begin
          rx_byte  <= line_bytes.pop_front();
          rx_valid <= 1'b1;
          rx_gap = idle_len(rx_burst);
        end else begin
          rx_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    sfr_item_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        beats_seen++;
        if (kind == KIND_VERDICT) verdicts_seen++;
        if (expected_beats.size() == 0) begin
          fail_count++;
          $display("%0t: beat with nothing expected, got kind %0d data %0h status %0d",
                   $time, kind, data, status);
        end else begin
          want = expected_beats.pop_front();
          check_field("kind", want.kind, kind);
          check_field("data", want.data, data);
          check_field("sender_id", want.sender_id, sender_id);
          check_field("frame_type", want.frame_type, frame_type);
          check_field("payload_length", want.payload_length, payload_length);
          check_field("status", want.status, status);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
        stall_left = idle_len(stall_burst);
      end
    end
  end

  initial begin
    logic [7:0] pl[$];
    logic [7:0] fb[$];
    logic [7:0] node_v;
    logic [7:0] start_v;
    logic [7:0] end_v;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Registers at their reset values: a stray byte, then an empty good frame
    line_bytes.push_back(8'hFF);
    pl = {};
    build_frame(8'h00, 8'h00, 8'h00, pl, 1'b0, 1'b0, fb);
    send(fb);
    wait_drained();

    write_reg(CFG_NODE_ID, 8'hFF);
    write_reg(CFG_START_BYTE, 8'hFF);
    write_reg(CFG_END_BYTE, 8'h00);
    @(negedge clk);
    // both end byte and CRC wrong
    pl = {8'h00, 8'hFF};
    build_frame(8'hFF, 8'hFF, 8'hFF, pl, 1'b1, 1'b1, fb);
    send(fb);
    // frame for another node; node_id moves onto it part-way through
    pl = {8'hA5};
    build_frame(8'h3C, 8'h12, 8'h01, pl, 1'b0, 1'b1, fb);
    repeat (7) line_bytes.push_back(fb.pop_front());
    wait_drained();
    write_reg(CFG_NODE_ID, 8'h12);
    @(negedge clk);
    send(fb);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          node_v = 8'h00; start_v = 8'hFF; end_v = 8'h00;
        end
        1: begin
          node_v = 8'hFF; start_v = 8'h00; end_v = 8'hFF;
        end
        default: begin
          node_v = 8'($urandom); start_v = 8'($urandom); end_v = 8'($urandom);
        end
      endcase
      write_reg(CFG_NODE_ID, node_v);
      write_reg(CFG_START_BYTE, start_v);
      write_reg(CFG_END_BYTE, end_v);
      @(negedge clk);
      random_traffic(PHASE_BYTES);
      wait_drained();
    end

    $display("Sent %0d bytes in %0d frames plus noise across %0d register settings;",
             bytes_sent, frames_built, NUM_PHASES + 3);
    $display("checked %0d result beats, %0d of them verdicts.", beats_seen, verdicts_seen);
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d beats still expected", expected_beats.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
